FILE: sv/ssd_pkg.sv
// Shared types, constants and helpers for the servo sweep with segment readout.
// No dependencies; every other file of the block imports this package.
package ssd_pkg;

    localparam int unsigned DIST_W   = 12;
    localparam int unsigned ANGLE_W  = 8;
    localparam int unsigned STEP_W   = 7;
    localparam int unsigned PULSE_W  = 11;
    localparam int unsigned LOW_W    = 32;
    localparam int unsigned HIGH_W   = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [DIST_W-1:0]  SEG_LIMIT   = 12'd999;
    localparam logic [PULSE_W-1:0] PULSE_MAX   = 11'd2047;
    localparam logic [3:0]         PULSE_SCALE = 4'd10;

    localparam logic [STEP_W-1:0]  STEP_RESET = 7'd5;
    localparam logic [ANGLE_W-1:0] MAX_RESET  = 8'd180;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP = 2'd0,
        REG_MAX  = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [STEP_W-1:0]  step_deg;
        logic [ANGLE_W-1:0] max_deg;
    } t_cfg;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [PULSE_W-1:0] pulse;
    } t_sweep;

    typedef struct packed {
        logic [LOW_W-1:0]  low_word;
        logic [HIGH_W-1:0] high_word;
    } t_seg_words;

    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = 8'h3F;
        endcase
        return code;
    endfunction

endpackage

FILE: sv/ssd_ifs.sv
// Channel interfaces: range tick input, result output and register write port.
// Depends on ssd_pkg for field widths.
interface ssd_in_if;
    import ssd_pkg::*;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance_cm;
    modport source (output valid, output distance_cm, input ready);
    modport sink   (input valid, input distance_cm, output ready);
endinterface

interface ssd_out_if;
    import ssd_pkg::*;
    logic               valid;
    logic               ready;
    logic [PULSE_W-1:0] servo_pulse;
    logic [ANGLE_W-1:0] shown_angle;
    logic [LOW_W-1:0]   hex_low_word;
    logic [HIGH_W-1:0]  hex_high_word;
    modport source (output valid, output servo_pulse, output shown_angle,
                    output hex_low_word, output hex_high_word, input ready);
    modport sink   (input valid, input servo_pulse, input shown_angle,
                    input hex_low_word, input hex_high_word, output ready);
endinterface

interface ssd_cfg_if;
    import ssd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/servo_sweep_with_display_top.sv
// Top level: register port, sweep state, segment encoder and result register.
// Depends on ssd_pkg, ssd_ifs, ssd_sweep and ssd_seg_enc.
//
//   channel  | dir | payload                                            | ready
//   i_in     | in  | distance_cm                                        | out reg free
//   o_out    | out | servo_pulse, shown_angle, hex_low_word, hex_high_word | from sink
//   i_cfg    | in  | index, data                                        | always high
//
// One tick per cycle while i_in is ready: a transaction on i_in is computed in a
// single pass and lands in the result register at the same edge that accepts it.
// The result register is the only stall point: i_in is ready while it is
// empty or being drained by o_out in the same cycle.
// Synchronous active-low reset restores step 5, max 180, angle 0 ascending
// and zeroed held display words.
module servo_sweep_with_display_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssd_in_if.sink     i_in,
    ssd_out_if.source  o_out,
    ssd_cfg_if.sink    i_cfg
);
    import ssd_pkg::*;

    t_cfg               r_cfg;
    t_sweep             sweep;
    t_seg_words         words;
    logic               in_acc;
    logic               cfg_acc;
    logic               shown_new;

    logic               r_out_valid;
    logic [PULSE_W-1:0] r_pulse;
    logic [ANGLE_W-1:0] r_angle;
    logic [LOW_W-1:0]   r_low;
    logic [HIGH_W-1:0]  r_high;
    logic [LOW_W-1:0]   r_held_low;
    logic [HIGH_W-1:0]  r_held_high;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_acc      = i_in.valid && i_in.ready;
    assign shown_new   = i_in.distance_cm <= SEG_LIMIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_deg <= STEP_RESET;
            r_cfg.max_deg  <= MAX_RESET;
        end else if (cfg_acc) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_STEP: r_cfg.step_deg <= i_cfg.data[STEP_W-1:0];
                REG_MAX:  r_cfg.max_deg  <= i_cfg.data[ANGLE_W-1:0];
                default:  ;
            endcase
        end
    end

    ssd_sweep u_sweep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (in_acc),
        .i_cfg     (r_cfg),
        .o_sweep   (sweep)
    );

    ssd_seg_enc u_seg_enc (
        .i_dist  (i_in.distance_cm[9:0]),
        .i_angle (sweep.angle),
        .o_words (words)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_held_low  <= '0;
            r_held_high <= '0;
        end else begin
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            // Out-of-range readings keep the last display words
            if (in_acc && shown_new) begin
                r_held_low  <= words.low_word;
                r_held_high <= words.high_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pulse <= sweep.pulse;
            r_angle <= sweep.angle;
            r_low   <= shown_new ? words.low_word  : r_held_low;
            r_high  <= shown_new ? words.high_word : r_held_high;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.servo_pulse   = r_pulse;
    assign o_out.shown_angle   = r_angle;
    assign o_out.hex_low_word  = r_low;
    assign o_out.hex_high_word = r_high;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out.valid)
        else $error("accepted tick did not produce a result");

    a_pulse_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.shown_angle <= 8'd204)) |->
        (o_out.servo_pulse == 11'(11'(o_out.shown_angle) * 11'd10)))
        else $error("servo pulse does not match shown angle");

    a_angle_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !cfg_acc) |=> (sweep.angle <= r_cfg.max_deg))
        else $error("angle left the sweep range");

    a_held_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> ((r_low == r_held_low) && (r_high == r_held_high)))
        else $error("shown display words differ from held words");
`endif

endmodule

FILE: sv/ssd_sweep.sv
// Sweep state: current angle and direction, servo pulse for the current angle.
// Depends on ssd_pkg.
module ssd_sweep (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_advance,
    input  ssd_pkg::t_cfg i_cfg,
    output ssd_pkg::t_sweep o_sweep
);
    import ssd_pkg::*;

    logic [ANGLE_W-1:0] r_angle;
    logic               r_desc;
    logic [ANGLE_W-1:0] n_angle;
    logic               n_desc;
    logic [ANGLE_W:0]   moved;
    logic [PULSE_W:0]   pulse_full;

    // Pulse is ten times the angle, saturated to the field width
    assign pulse_full = (PULSE_W+1)'(r_angle) * (PULSE_W+1)'(PULSE_SCALE);
    assign o_sweep.angle = r_angle;
    assign o_sweep.pulse = pulse_full[PULSE_W] ? PULSE_MAX : pulse_full[PULSE_W-1:0];

    always_comb begin
        if (r_angle >= i_cfg.max_deg) begin
            n_desc = 1'b1;
        end else if (r_angle == '0) begin
            n_desc = 1'b0;
        end else begin
            n_desc = r_desc;
        end

        // Move by one step, floor at zero, then clamp to the turning point
        if (n_desc) begin
            moved = ((ANGLE_W+1)'(r_angle) < (ANGLE_W+1)'(i_cfg.step_deg)) ? '0 :
                    (ANGLE_W+1)'(r_angle) - (ANGLE_W+1)'(i_cfg.step_deg);
        end else begin
            moved = (ANGLE_W+1)'(r_angle) + (ANGLE_W+1)'(i_cfg.step_deg);
        end

        if (moved > (ANGLE_W+1)'(i_cfg.max_deg)) begin
            n_angle = i_cfg.max_deg;
        end else begin
            n_angle = moved[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            r_desc  <= 1'b0;
        end else if (i_advance) begin
            r_angle <= n_angle;
            r_desc  <= n_desc;
        end
    end

endmodule

FILE: sv/ssd_seg_enc.sv
// Decimal digit split and seven-segment encoding of distance and angle.
// Depends on ssd_pkg (seg_of, widths).
module ssd_seg_enc (
    input  logic [9:0]                i_dist,
    input  logic [ssd_pkg::ANGLE_W-1:0] i_angle,
    output ssd_pkg::t_seg_words       o_words
);
    import ssd_pkg::*;

    logic [17:0] d_p10;
    logic [15:0] d_p100;
    logic [6:0]  d_q10;
    logic [3:0]  d_q100;
    logic [3:0]  d_ones;
    logic [3:0]  d_tens;

    logic [15:0] a_p10;
    logic [13:0] a_p100;
    logic [4:0]  a_q10;
    logic [1:0]  a_q100;
    logic [3:0]  a_ones;
    logic [3:0]  a_tens;

    // Divide by 10 and 100 through reciprocal multiplies, exact over these ranges
    assign d_p10  = 18'(i_dist) * 18'd205;
    assign d_q10  = d_p10[17:11];
    assign d_p100 = 16'(i_dist) * 16'd41;
    assign d_q100 = d_p100[15:12];
    assign d_ones = 4'(i_dist - 10'(10'(d_q10) * 10'd10));
    assign d_tens = 4'(d_q10 - 7'(7'(d_q100) * 7'd10));

    assign a_p10  = 16'(i_angle) * 16'd205;
    assign a_q10  = a_p10[15:11];
    assign a_p100 = 14'(i_angle) * 14'd41;
    assign a_q100 = a_p100[13:12];
    assign a_ones = 4'(i_angle - 8'(8'(a_q10) * 8'd10));
    assign a_tens = 4'(a_q10 - 5'(5'(a_q100) * 5'd10));

    assign o_words.low_word  = {seg_of(a_ones), seg_of(d_q100), seg_of(d_tens),
                                seg_of(d_ones)};
    assign o_words.high_word = {seg_of({2'b00, a_q100}), seg_of(a_tens)};

endmodule
